@@ design/vga_dac_palette_ports_defines.svh @@
// Assertion macros for the palette port RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef VGA_DAC_PALETTE_PORTS_DEFINES_SVH
`define VGA_DAC_PALETTE_PORTS_DEFINES_SVH

// Same-cycle implication, clocked on clock, off during reset.
`define VDP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, clocked on clock, off during reset.
`define VDP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/vdp_pkg.sv @@
// Package for the VGA DAC palette ports: command codes, component codes, types.
// No dependencies.
`timescale 1ns / 1ps

package vdp_pkg;

   localparam int INDEX_W     = 8;    // width of data and entry_index
   localparam int INDEX_RANGE = 256;  // codes an 8-bit index can take
   localparam int IN_COMP_W   = 6;    // width of red/green/blue/read_data fields

   typedef logic [2:0] cmd_type;
   localparam cmd_type CMD_SET_READ   = 3'd0;
   localparam cmd_type CMD_SET_WRITE  = 3'd1;
   localparam cmd_type CMD_WRITE_DATA = 3'd2;
   localparam cmd_type CMD_READ_DATA  = 3'd3;
   localparam cmd_type CMD_DIRECT_SET = 3'd4;

   typedef logic [1:0] comp_type;
   localparam comp_type COMP_RED   = 2'd0;
   localparam comp_type COMP_GREEN = 2'd1;
   localparam comp_type COMP_BLUE  = 2'd2;

   // Pointer control from the command decode.
   typedef struct packed {
      logic set;   // load index, restart at red
      logic step;  // advance one component
   } ptr_ctl_type;

endpackage

@@ design/vdp_if.sv @@
// Request and response channel interfaces of the palette ports.
// Depends on vdp_pkg.
`timescale 1ns / 1ps

interface vdp_req_if import vdp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   cmd_type              cmd;
   logic [INDEX_W-1:0]   data;
   logic [INDEX_W-1:0]   entry_index;
   logic [IN_COMP_W-1:0] red;
   logic [IN_COMP_W-1:0] green;
   logic [IN_COMP_W-1:0] blue;

   modport source (output valid, cmd, data, entry_index, red, green, blue, input ready);
   modport sink   (input valid, cmd, data, entry_index, red, green, blue, output ready);
endinterface

interface vdp_rsp_if import vdp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [IN_COMP_W-1:0] read_data;

   modport source (output valid, read_data, input ready);
   modport sink   (input valid, read_data, output ready);
endinterface

@@ design/vga_dac_palette_ports.sv @@
// Top level of the VGA DAC palette ports: decode, pointers, palette, response.
// Depends on vdp_pkg, vdp_if, vdp_wrap, vdp_ptr, vdp_ram.
//
//   channel   dir  fields
//   req_chan  in   cmd, data, entry_index, red, green, blue
//   rsp_chan  out  read_data (one response per request)
//
// One request per cycle; its response is valid the cycle after acceptance.
// All work is done at the accept edge; the palette read port registers the
// component for a data read, and that register feeds the response.
// A stalled response holds; a new request is taken in the cycle it drains.
// Synchronous reset clears pointers and the response valid; palette contents
// stay undefined until written.
`timescale 1ns / 1ps

module vga_dac_palette_ports import vdp_pkg::*; #(
   parameter int COLOR_COUNT = 256,
   parameter int COMPONENT_BITS = 6
) (
   input logic       clock,
   input logic       reset,
   vdp_req_if.sink   req_chan,
   vdp_rsp_if.source rsp_chan
);

   localparam int PTR_W = $clog2(COLOR_COUNT);

   logic             accept;
   ptr_ctl_type      rd_ctl, wr_ctl;
   logic [PTR_W-1:0] data_idx, entry_idx;
   logic [PTR_W-1:0] rd_ptr, wr_ptr;
   comp_type         rd_comp, wr_comp;

   logic [2:0]                we;
   logic [PTR_W-1:0]          wr_addr;
   logic [COMPONENT_BITS-1:0] wr_red, wr_green, wr_blue;
   logic                      rd_en;
   logic [COMPONENT_BITS-1:0] rd_red, rd_green, rd_blue;
   logic [COMPONENT_BITS-1:0] rd_sel;

   logic     rsp_valid_ff, rsp_valid_in;
   logic     is_read_ff;
   comp_type sel_ff;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   vdp_wrap #(.COLOR_COUNT(COLOR_COUNT)) u_data_wrap (
      .raw (req_chan.data),
      .idx (data_idx)
   );

   vdp_wrap #(.COLOR_COUNT(COLOR_COUNT)) u_entry_wrap (
      .raw (req_chan.entry_index),
      .idx (entry_idx)
   );

   always_comb begin
      rd_ctl   = '0;
      wr_ctl   = '0;
      we       = '0;
      rd_en    = 1'b0;
      wr_addr  = wr_ptr;
      wr_red   = req_chan.data[COMPONENT_BITS-1:0];
      wr_green = req_chan.data[COMPONENT_BITS-1:0];
      wr_blue  = req_chan.data[COMPONENT_BITS-1:0];
      if (accept) begin
         case (req_chan.cmd)
            CMD_SET_READ:   rd_ctl.set = 1'b1;
            CMD_SET_WRITE:  wr_ctl.set = 1'b1;
            CMD_WRITE_DATA: begin
               wr_ctl.step  = 1'b1;
               we[wr_comp]  = 1'b1;
            end
            CMD_READ_DATA: begin
               rd_ctl.step = 1'b1;
               rd_en       = 1'b1;
            end
            CMD_DIRECT_SET: begin
               we       = 3'b111;
               wr_addr  = entry_idx;
               wr_red   = COMPONENT_BITS'(req_chan.red);
               wr_green = COMPONENT_BITS'(req_chan.green);
               wr_blue  = COMPONENT_BITS'(req_chan.blue);
            end
            default: ;
         endcase
      end
   end

   vdp_ptr #(.COLOR_COUNT(COLOR_COUNT)) u_rd_ptr (
      .clock (clock),
      .reset (reset),
      .ctl   (rd_ctl),
      .index (data_idx),
      .ptr   (rd_ptr),
      .comp  (rd_comp)
   );

   vdp_ptr #(.COLOR_COUNT(COLOR_COUNT)) u_wr_ptr (
      .clock (clock),
      .reset (reset),
      .ctl   (wr_ctl),
      .index (data_idx),
      .ptr   (wr_ptr),
      .comp  (wr_comp)
   );

   vdp_ram #(.COLOR_COUNT(COLOR_COUNT), .COMP_W(COMPONENT_BITS)) u_ram (
      .clock    (clock),
      .we       (we),
      .wr_addr  (wr_addr),
      .wr_red   (wr_red),
      .wr_green (wr_green),
      .wr_blue  (wr_blue),
      .rd_en    (rd_en),
      .rd_addr  (rd_ptr),
      .rd_red   (rd_red),
      .rd_green (rd_green),
      .rd_blue  (rd_blue)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept)
         rsp_valid_in = 1'b1;
      else if (rsp_chan.ready)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload side info; held while the response stalls.
   always_ff @(posedge clock) begin
      if (accept) begin
         is_read_ff <= (req_chan.cmd == CMD_READ_DATA);
         sel_ff     <= rd_comp;
      end
   end

   always_comb begin
      case (sel_ff)
         COMP_RED:   rd_sel = rd_red;
         COMP_GREEN: rd_sel = rd_green;
         COMP_BLUE:  rd_sel = rd_blue;
         default:    rd_sel = '0;
      endcase
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.read_data = is_read_ff ? rd_sel[IN_COMP_W-1:0] : '0;

endmodule

@@ design/vdp_wrap.sv @@
// Reduces an 8-bit palette index modulo the palette size via a constant table.
// Depends on vdp_pkg.
`timescale 1ns / 1ps

module vdp_wrap import vdp_pkg::*; #(
   parameter int COLOR_COUNT = 256,
   localparam int PTR_W = $clog2(COLOR_COUNT)
) (
   input  logic [INDEX_W-1:0] raw,
   output logic [PTR_W-1:0]   idx
);

   logic [PTR_W-1:0] wrap_tbl [INDEX_RANGE];

   for (genvar i = 0; i < INDEX_RANGE; i++) begin : g_tbl
      assign wrap_tbl[i] = PTR_W'(i % COLOR_COUNT);
   end

   assign idx = wrap_tbl[raw];

endmodule

@@ design/vdp_ptr.sv @@
// Palette pointer with its red/green/blue component counter.
// Depends on vdp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "vga_dac_palette_ports_defines.svh"

module vdp_ptr import vdp_pkg::*; #(
   parameter int COLOR_COUNT = 256,
   localparam int PTR_W = $clog2(COLOR_COUNT)
) (
   input  logic             clock,
   input  logic             reset,
   input  ptr_ctl_type      ctl,
   input  logic [PTR_W-1:0] index,
   output logic [PTR_W-1:0] ptr,
   output comp_type         comp
);

   localparam logic [PTR_W-1:0] LAST_ENTRY = PTR_W'(COLOR_COUNT - 1);

   logic [PTR_W-1:0] ptr_ff, ptr_in;
   comp_type         comp_ff, comp_in;

   always_comb begin
      ptr_in  = ptr_ff;
      comp_in = comp_ff;
      if (ctl.set) begin
         ptr_in  = index;
         comp_in = COMP_RED;
      end else if (ctl.step) begin
         if (comp_ff == COMP_BLUE) begin
            comp_in = COMP_RED;
            ptr_in  = (ptr_ff == LAST_ENTRY) ? '0 : ptr_ff + 1'b1;
         end else begin
            comp_in = comp_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff  <= '0;
         comp_ff <= COMP_RED;
      end else begin
         ptr_ff  <= ptr_in;
         comp_ff <= comp_in;
      end
   end

   assign ptr  = ptr_ff;
   assign comp = comp_ff;

   `VDP_ASSERT_NOW(a_comp_legal, 1'b1, comp_ff != 2'd3, "component counter out of range")
   `VDP_ASSERT_NEXT(a_set_loads, ctl.set, (ptr_ff == $past(index)) && (comp_ff == COMP_RED), "index load lost")
   `VDP_ASSERT_NEXT(a_blue_wraps, ctl.step && !ctl.set && (comp_ff == COMP_BLUE), (comp_ff == COMP_RED) && (ptr_ff != $past(ptr_ff)), "no advance after blue")
   `VDP_ASSERT_NEXT(a_idle_holds, !ctl.set && !ctl.step, $stable(ptr_ff) && $stable(comp_ff), "pointer moved without a request")

endmodule

@@ design/vdp_ram.sv @@
// Palette storage: one bank per color component, one write and one read port.
// Depends on vdp_pkg.
`timescale 1ns / 1ps

module vdp_ram import vdp_pkg::*; #(
   parameter int COLOR_COUNT = 256,
   parameter int COMP_W = 6,
   localparam int PTR_W = $clog2(COLOR_COUNT)
) (
   input  logic              clock,
   input  logic [2:0]        we,       // bit per bank: red, green, blue
   input  logic [PTR_W-1:0]  wr_addr,
   input  logic [COMP_W-1:0] wr_red,
   input  logic [COMP_W-1:0] wr_green,
   input  logic [COMP_W-1:0] wr_blue,
   input  logic              rd_en,
   input  logic [PTR_W-1:0]  rd_addr,
   output logic [COMP_W-1:0] rd_red,
   output logic [COMP_W-1:0] rd_green,
   output logic [COMP_W-1:0] rd_blue
);

   logic [COMP_W-1:0] red_mem   [COLOR_COUNT];
   logic [COMP_W-1:0] green_mem [COLOR_COUNT];
   logic [COMP_W-1:0] blue_mem  [COLOR_COUNT];
   logic [COMP_W-1:0] rd_red_ff, rd_green_ff, rd_blue_ff;

   always_ff @(posedge clock) begin
      if (we[COMP_RED])   red_mem[wr_addr]   <= wr_red;
      if (we[COMP_GREEN]) green_mem[wr_addr] <= wr_green;
      if (we[COMP_BLUE])  blue_mem[wr_addr]  <= wr_blue;
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_red_ff   <= red_mem[rd_addr];
         rd_green_ff <= green_mem[rd_addr];
         rd_blue_ff  <= blue_mem[rd_addr];
      end
   end

   assign rd_red   = rd_red_ff;
   assign rd_green = rd_green_ff;
   assign rd_blue  = rd_blue_ff;

endmodule

@@ bench/palette_port_checker.sv @@
// Response checker for the palette ports: tracks the palette and both pointers,
// predicts read_data for each accepted request and compares it with the response.
// Depends on vdp_pkg and vdp_if.
`timescale 1ns / 1ps

module palette_port_checker import vdp_pkg::*; #(
   parameter int COLOR_COUNT    = 256,
   parameter int COMPONENT_BITS = 6
) (
   input  logic clock,
   input  logic reset,
   vdp_req_if   req_mon,
   vdp_rsp_if   rsp_mon,
   output int   mismatches,
   output int   outstanding,
   output int   reads_seen
);

   typedef logic [IN_COMP_W-1:0] shade_t;

   localparam int SLOTS = 3;  // red, green, blue per entry

   shade_t      palette [COLOR_COUNT][SLOTS];
   int unsigned wr_entry, wr_slot, rd_entry, rd_slot;
   shade_t      due_read_data [$];
   int          err_total, read_total;

   function automatic void advance_slot(inout int unsigned entry, inout int unsigned slot);
      slot++;
      if (slot == SLOTS) begin
         slot  = 0;
         entry = (entry + 1) % COLOR_COUNT;
      end
   endfunction

   // Applies one request to the tracked state and returns the component it reads back.
   function automatic shade_t apply_request(cmd_type cmd, logic [INDEX_W-1:0] data,
                                            logic [INDEX_W-1:0] entry, shade_t r, shade_t g,
                                            shade_t b);
      shade_t comp;
      comp = '0;
      case (cmd)
         CMD_SET_READ: begin
            rd_entry = data % COLOR_COUNT;
            rd_slot  = COMP_RED;
         end
         CMD_SET_WRITE: begin
            wr_entry = data % COLOR_COUNT;
            wr_slot  = COMP_RED;
         end
         CMD_WRITE_DATA: begin
            palette[wr_entry][wr_slot] = shade_t'(data & ((1 << COMPONENT_BITS) - 1));
            advance_slot(wr_entry, wr_slot);
         end
         CMD_READ_DATA: begin
            comp = palette[rd_entry][rd_slot];
            advance_slot(rd_entry, rd_slot);
         end
         CMD_DIRECT_SET: begin
            palette[entry % COLOR_COUNT][COMP_RED]   = r;
            palette[entry % COLOR_COUNT][COMP_GREEN] = g;
            palette[entry % COLOR_COUNT][COMP_BLUE]  = b;
         end
         default: ;
      endcase
      return comp;
   endfunction

   initial begin
      err_total   = 0;
      read_total  = 0;
      mismatches  = 0;
      outstanding = 0;
      reads_seen  = 0;
   end

   always @(posedge clock) begin
      shade_t want;
      if (reset) begin
         wr_entry = 0;
         wr_slot  = 0;
         rd_entry = 0;
         rd_slot  = 0;
         due_read_data.delete();
      end else begin
         // drain first: a response at this edge belongs to an older request
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (due_read_data.size() == 0) begin
               if (err_total < 10)
                  $display("%0t checker: response %0d with no request pending",
                           $realtime, rsp_mon.read_data);
               err_total++;
            end else begin
               want = due_read_data.pop_front();
               if (rsp_mon.read_data !== want) begin
                  if (err_total < 10)
                     $display("%0t checker: read_data expected %0d, got %0d",
                              $realtime, want, rsp_mon.read_data);
                  err_total++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.cmd == CMD_READ_DATA)
               read_total++;
            due_read_data.push_back(apply_request(req_mon.cmd, req_mon.data,
                                                  req_mon.entry_index, req_mon.red,
                                                  req_mon.green, req_mon.blue));
         end
      end
      mismatches  <= err_total;
      outstanding <= due_read_data.size();
      reads_seen  <= read_total;
   end

endmodule

@@ bench/tb_top.sv @@
// Testbench top for vga_dac_palette_ports: clock, reset, request stimulus,
// response back-pressure, watchdog and verdict.
// Depends on vdp_pkg, vdp_if, the palette port RTL and palette_port_checker.
`timescale 1ns / 1ps

module tb_top;
   import vdp_pkg::*;

   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int TOTAL_REQUESTS  = 1100;
   localparam int CALM_TAIL       = 150;
   localparam int HOLD_OFF_AT     = 400;
   localparam int HOLD_OFF_CYCLES = 64;

   // codes the block decodes as no-ops
   localparam cmd_type CMD_SPARE_A = 3'd5;
   localparam cmd_type CMD_SPARE_B = 3'd6;
   localparam cmd_type CMD_SPARE_C = 3'd7;

   localparam bit [2:0] ALL_LOADED = 3'b111;

   logic clock;
   logic reset;

   vdp_req_if req_chan ();
   vdp_rsp_if rsp_chan ();

   int mismatches, outstanding, reads_seen;
   int sent;
   int idle_cycles;
   bit calm;

   // which components have been written, kept so no unwritten entry is ever read
   bit [2:0]    loaded [INDEX_RANGE];
   int unsigned wr_at, wr_sub, rd_at, rd_sub;

   vga_dac_palette_ports dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   palette_port_checker port_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .reads_seen  (reads_seen)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic void advance_slot(inout int unsigned entry, inout int unsigned slot);
      slot++;
      if (slot == 3) begin
         slot  = 0;
         entry = (entry + 1) % INDEX_RANGE;
      end
   endfunction

   // mostly any index, often one near the top so the pointers wrap
   function automatic logic [INDEX_W-1:0] pick_index();
      if ($urandom_range(0, 3) == 0)
         return INDEX_W'($urandom_range(250, 255));
      return INDEX_W'($urandom);
   endfunction

   task automatic issue(cmd_type cmd, logic [INDEX_W-1:0] data, logic [INDEX_W-1:0] entry,
                        logic [IN_COMP_W-1:0] r, logic [IN_COMP_W-1:0] g,
                        logic [IN_COMP_W-1:0] b);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.cmd         <= cmd;
      req_chan.data        <= data;
      req_chan.entry_index <= entry;
      req_chan.red         <= r;
      req_chan.green       <= g;
      req_chan.blue        <= b;
      do @(posedge clock); while (!req_chan.ready);
      case (cmd)
         CMD_SET_READ: begin
            rd_at  = data;
            rd_sub = 0;
         end
         CMD_SET_WRITE: begin
            wr_at  = data;
            wr_sub = 0;
         end
         CMD_WRITE_DATA: begin
            loaded[wr_at][wr_sub] = 1'b1;
            advance_slot(wr_at, wr_sub);
         end
         CMD_READ_DATA: advance_slot(rd_at, rd_sub);
         CMD_DIRECT_SET: loaded[entry] = ALL_LOADED;
         default: ;
      endcase
      sent++;
   endtask

   // request with random filler in the fields the command ignores
   task automatic issue_filled(cmd_type cmd, logic [INDEX_W-1:0] data);
      issue(cmd, data, INDEX_W'($urandom), IN_COMP_W'($urandom), IN_COMP_W'($urandom),
            IN_COMP_W'($urandom));
   endtask

   task automatic write_run(int count);
      repeat (count) issue_filled(CMD_WRITE_DATA, INDEX_W'($urandom));
   endtask

   task automatic read_run(int count);
      for (int i = 0; i < count; i++) begin
         if (!loaded[rd_at][rd_sub])
            break;
         issue_filled(CMD_READ_DATA, INDEX_W'($urandom));
      end
   endtask

   task automatic direct_set(logic [INDEX_W-1:0] entry);
      issue(CMD_DIRECT_SET, INDEX_W'($urandom), entry, IN_COMP_W'($urandom),
            IN_COMP_W'($urandom), IN_COMP_W'($urandom));
   endtask

   // response side: random stalls, one long hold-off, none near the end
   initial begin
      bit held;
      held = 1'b0;
      rsp_chan.ready <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         if (!held && sent >= HOLD_OFF_AT) begin
            held = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("tb_top: watchdog expired after %0d idle cycles", WATCHDOG_LIMIT);
      $display("tb_top: done, errors");
      $finish;
   end

   initial begin
      int pick;
      logic [INDEX_W-1:0] idx;
      sent        = 0;
      calm        = 1'b0;
      idle_cycles = 0;
      wr_at       = 0;
      wr_sub      = 0;
      rd_at       = 0;
      rd_sub      = 0;
      foreach (loaded[i]) loaded[i] = '0;
      req_chan.valid       <= 1'b0;
      req_chan.cmd         <= CMD_SET_READ;
      req_chan.data        <= '0;
      req_chan.entry_index <= '0;
      req_chan.red         <= '0;
      req_chan.green       <= '0;
      req_chan.blue        <= '0;
      reset <= 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, wrap of both pointers, wide write data,
      // read index restarting at red, the unused codes
      issue(CMD_DIRECT_SET, 8'h00, 8'h00, 6'h00, 6'h00, 6'h00);
      issue(CMD_DIRECT_SET, 8'hFF, 8'hFF, 6'h3F, 6'h3F, 6'h3F);
      issue(CMD_SET_WRITE, 8'hFF, 8'h00, 6'h00, 6'h00, 6'h00);
      issue(CMD_WRITE_DATA, 8'hFF, 8'h00, 6'h00, 6'h00, 6'h00);
      issue(CMD_WRITE_DATA, 8'hC0, 8'h00, 6'h00, 6'h00, 6'h00);
      issue(CMD_WRITE_DATA, 8'h2A, 8'h00, 6'h00, 6'h00, 6'h00);
      issue(CMD_WRITE_DATA, 8'h15, 8'h00, 6'h00, 6'h00, 6'h00);
      issue(CMD_SET_READ, 8'hFF, 8'h00, 6'h00, 6'h00, 6'h00);
      repeat (5) issue(CMD_READ_DATA, 8'h00, 8'h00, 6'h00, 6'h00, 6'h00);
      issue(CMD_SET_READ, 8'hFF, 8'hFF, 6'h3F, 6'h3F, 6'h3F);
      issue(CMD_READ_DATA, 8'hFF, 8'hFF, 6'h3F, 6'h3F, 6'h3F);
      issue(CMD_SET_READ, 8'hFF, 8'h00, 6'h00, 6'h00, 6'h00);
      issue(CMD_READ_DATA, 8'h00, 8'h00, 6'h00, 6'h00, 6'h00);
      issue(CMD_SPARE_A, 8'hFF, 8'hFF, 6'h3F, 6'h3F, 6'h3F);
      issue(CMD_SPARE_B, 8'hFF, 8'hFF, 6'h3F, 6'h3F, 6'h3F);
      issue(CMD_SPARE_C, 8'hFF, 8'hFF, 6'h3F, 6'h3F, 6'h3F);
      issue(CMD_SET_WRITE, 8'h01, 8'h00, 6'h00, 6'h00, 6'h00);
      issue(CMD_WRITE_DATA, 8'h3F, 8'h00, 6'h00, 6'h00, 6'h00);
      issue(CMD_SET_READ, 8'h01, 8'h00, 6'h00, 6'h00, 6'h00);
      issue(CMD_READ_DATA, 8'h00, 8'h00, 6'h00, 6'h00, 6'h00);

      // random: mostly index-then-data sequences, some loose requests and noise
      while (sent < TOTAL_REQUESTS) begin
         calm = (TOTAL_REQUESTS - sent) < CALM_TAIL;
         pick = $urandom_range(0, 99);
         if (pick < 25) begin
            issue_filled(CMD_SET_WRITE, pick_index());
            write_run($urandom_range(1, 9));
         end else if (pick < 55) begin
            idx = pick_index();
            if (loaded[idx] != ALL_LOADED)
               direct_set(idx);
            issue_filled(CMD_SET_READ, idx);
            read_run($urandom_range(1, 9));
         end else if (pick < 72) begin
            direct_set(pick_index());
         end else if (pick < 82) begin
            read_run($urandom_range(1, 3));
         end else if (pick < 90) begin
            write_run($urandom_range(1, 3));
         end else if (pick < 95) begin
            issue_filled(($urandom_range(0, 1) == 0) ? CMD_SET_READ : CMD_SET_WRITE,
                         INDEX_W'($urandom));
         end else begin
            issue_filled(cmd_type'($urandom_range(CMD_SPARE_A, CMD_SPARE_C)),
                         INDEX_W'($urandom));
         end
      end
      req_chan.valid <= 1'b0;

      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);

      $display("tb_top: %0d requests driven, %0d of them palette data reads", sent, reads_seen);
      $display("tb_top: %0d mismatches, response held off %0d cycles once", mismatches,
               HOLD_OFF_CYCLES);
      if (mismatches == 0 && outstanding == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule
